// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the sequencer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SCT0_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sct0: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SCT0_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sct0: next-cycle check failed");

`endif

// ----- hw/rtl/sct0_pkg.sv -----
// Types and constants of the smart-card T=0 sequencer.
`default_nettype none

package sct0_pkg;

  // Transmit queue geometry
  localparam int unsigned TX_QUEUE_DEPTH = 16;
  localparam int unsigned QIDX_W = (TX_QUEUE_DEPTH > 1) ? $clog2(TX_QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(TX_QUEUE_DEPTH + 1);
  localparam int unsigned QSUM_W = QIDX_W + 1;

  // Protocol constants
  localparam logic [8:0] MAX_LENGTH   = 9'd256;
  localparam logic [2:0] HEADER_BYTES = 3'd5;
  localparam logic [7:0] NULL_BYTE    = 8'h60;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INSTRUCTION_CODE  = 2'd0,
    CFG_RECEIVE_DIRECTION = 2'd1,
    CFG_TRANSFER_LENGTH   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_CARD_BYTE = 3'd0,
    OP_HOST_TX   = 3'd1,
    OP_HOST_RX   = 3'd2,
    OP_TX_SLOT   = 3'd3,
    OP_START     = 3'd4,
    OP_STOP      = 3'd5,
    OP_CLEAR     = 3'd6
  } opcode_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_PROC   = 3'd2,
    PH_SEND   = 3'd3,
    PH_RECV   = 3'd4,
    PH_SW1    = 3'd5,
    PH_SW2    = 3'd6
  } phase_e;

  // Result fields known at accept time (the sent byte comes later from the queue RAM)
  typedef struct packed {
    phase_e     phase;
    logic       tx_valid;
    logic [7:0] rx_byte;
    logic       rx_ready;
    logic [7:0] status_word1;
    logic [7:0] status_word2;
    logic       command_done;
    logic       done_flag;
    logic       overrun_flag;
    logic       service_request;
  } stage_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sct0_req_if.sv -----
// Request channel of the sequencer: opcode and data byte.
`default_nettype none

interface sct0_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sct0_rsp_if.sv -----
// Result channel of the sequencer: phase, bytes and status flags.
`default_nettype none

interface sct0_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] phase;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic [7:0] rx_byte;
  logic       rx_ready;
  logic [7:0] status_word1;
  logic [7:0] status_word2;
  logic       command_done;
  logic       done_flag;
  logic       overrun_flag;
  logic       service_request;

  modport source (
    output valid, output phase, output tx_valid, output tx_byte, output rx_byte,
    output rx_ready, output status_word1, output status_word2, output command_done,
    output done_flag, output overrun_flag, output service_request,
    input ready
  );
  modport sink (
    input valid, input phase, input tx_valid, input tx_byte, input rx_byte,
    input rx_ready, input status_word1, input status_word2, input command_done,
    input done_flag, input overrun_flag, input service_request,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/sct0_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module sct0_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds its data while idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/smart_card_t0_sequencer_top.sv -----
// Top level of the smart-card T=0 transfer sequencer.
//
//   channel  dir  handshake          contents
//   req      in   valid/ready        opcode, data_byte
//   rsp      out  valid/ready        phase, tx byte, rx byte, status words, flags
//   cfg      in   cfg_we_i, no wait  cfg_idx_i selects register, cfg_data_i value
//
// One request per cycle is sustained while rsp.ready does not stall the output; a
// result is offered from the output register, behind the s1 register, once its request
// is accepted, the extra stage covering the registered read of the transmit queue RAM.
// Sequencer state lives in flops and is updated at accept; the queue bytes live in RAM.
// rst_ni clears all control state at once; queue RAM contents are not cleared and
// only entries written since reset are ever read, so no clearing pass is needed.
// A stalled result is held in the output register while one more request is taken.
`default_nettype none
`include "assert_macros.svh"

module smart_card_t0_sequencer_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [sct0_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sct0_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sct0_req_if.sink                            req,
  sct0_rsp_if.source                          rsp
);

  // Configuration registers
  logic [7:0] ins_code_q;
  logic       rx_dir_q;
  logic [7:0] xfer_len_q;

  // Sequencer state
  sct0_pkg::phase_e                phase_q, phase_d;
  logic [2:0]                      hdr_cnt_q, hdr_cnt_d;
  logic [8:0]                      data_len_q, data_len_d;
  logic [8:0]                      bytes_done_q, bytes_done_d;
  logic [8:0]                      chunk_left_q, chunk_left_d;
  logic [sct0_pkg::QIDX_W-1:0]     q_head_q, q_head_d;
  logic [sct0_pkg::QCNT_W-1:0]     queue_count_q, queue_count_d;
  logic                            tx_busy_q, tx_busy_d;
  logic                            rx_wait_q, rx_wait_d;
  logic [7:0]                      rx_hold_q, rx_hold_d;
  logic [7:0]                      sw1_q, sw1_d;
  logic [7:0]                      sw2_q, sw2_d;
  logic                            flag_done_q, flag_done_d;
  logic                            flag_ovr_q, flag_ovr_d;

  // Pipeline
  logic                            req_fire;
  logic                            s1_adv;
  logic                            s1_valid_q;
  sct0_pkg::stage_t                s1_q, s1_d;
  logic                            out_valid_q;
  sct0_pkg::stage_t                out_q;
  logic [7:0]                      out_tx_byte_q;

  // Queue RAM
  logic                            ram_we;
  logic [sct0_pkg::QIDX_W-1:0]     ram_waddr;
  logic                            ram_re;
  logic [7:0]                      ram_rdata;

  // Handshake and pipeline advance
  assign s1_adv    = s1_valid_q && (!out_valid_q || rsp.ready);
  assign req.ready = !s1_valid_q || s1_adv;
  assign req_fire  = req.valid && req.ready;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ins_code_q <= '0;
      rx_dir_q   <= 1'b0;
      xfer_len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (sct0_pkg::cfg_idx_e'(cfg_idx_i))
        sct0_pkg::CFG_INSTRUCTION_CODE:  ins_code_q <= cfg_data_i[7:0];
        sct0_pkg::CFG_RECEIVE_DIRECTION: rx_dir_q   <= cfg_data_i[0];
        sct0_pkg::CFG_TRANSFER_LENGTH:   xfer_len_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Next state of the sequencer for the request on the port
  always_comb begin
    logic [8:0]                  bd_inc;
    logic [8:0]                  cl_dec;
    sct0_pkg::phase_e            cnt_phase;
    logic [8:0]                  remaining;
    logic [2:0]                  hdr_inc;
    logic [sct0_pkg::QSUM_W-1:0] tail_sum;
    logic [sct0_pkg::QCNT_W-1:0] cnt_dec;
    logic                        done_pulse;
    logic                        tx_fire;

    phase_d       = phase_q;
    hdr_cnt_d     = hdr_cnt_q;
    data_len_d    = data_len_q;
    bytes_done_d  = bytes_done_q;
    chunk_left_d  = chunk_left_q;
    q_head_d      = q_head_q;
    queue_count_d = queue_count_q;
    tx_busy_d     = tx_busy_q;
    rx_wait_d     = rx_wait_q;
    rx_hold_d     = rx_hold_q;
    sw1_d         = sw1_q;
    sw2_d         = sw2_q;
    flag_done_d   = flag_done_q;
    flag_ovr_d    = flag_ovr_q;
    done_pulse    = 1'b0;
    tx_fire       = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    // Data counter advance shared by send and receive
    bd_inc = bytes_done_q + 9'd1;
    cl_dec = chunk_left_q - 9'd1;
    if (bd_inc == data_len_q) begin
      cnt_phase = sct0_pkg::PH_SW1;
    end else if (cl_dec == 9'd0) begin
      cnt_phase = sct0_pkg::PH_PROC;
    end else begin
      cnt_phase = phase_q;
    end
    remaining = data_len_q - bytes_done_q;
    hdr_inc   = hdr_cnt_q + 3'd1;
    cnt_dec   = queue_count_q - sct0_pkg::QCNT_W'(1);

    // Write address: head plus fill, wrapped once
    tail_sum = sct0_pkg::QSUM_W'(q_head_q) + sct0_pkg::QSUM_W'(queue_count_q);
    if (tail_sum >= sct0_pkg::QSUM_W'(sct0_pkg::TX_QUEUE_DEPTH)) begin
      tail_sum = tail_sum - sct0_pkg::QSUM_W'(sct0_pkg::TX_QUEUE_DEPTH);
    end
    ram_waddr = tail_sum[sct0_pkg::QIDX_W-1:0];

    if (req_fire) begin
      unique case (sct0_pkg::opcode_e'(req.opcode))
        sct0_pkg::OP_CARD_BYTE: begin
          unique case (phase_q)
            sct0_pkg::PH_PROC: begin
              if (req.data_byte == sct0_pkg::NULL_BYTE) begin
                // null procedure byte: ignore
              end else if (req.data_byte == ins_code_q) begin
                chunk_left_d = remaining;
                phase_d      = rx_dir_q ? sct0_pkg::PH_RECV : sct0_pkg::PH_SEND;
              end else if (req.data_byte == ~ins_code_q) begin
                chunk_left_d = (remaining == 9'd0) ? 9'd0 : 9'd1;
                phase_d      = rx_dir_q ? sct0_pkg::PH_RECV : sct0_pkg::PH_SEND;
              end else begin
                sw1_d   = req.data_byte;
                phase_d = sct0_pkg::PH_SW2;
              end
            end
            sct0_pkg::PH_RECV: begin
              if (rx_wait_q) begin
                flag_ovr_d = 1'b1;
              end else begin
                rx_hold_d    = req.data_byte;
                rx_wait_d    = 1'b1;
                bytes_done_d = bd_inc;
                chunk_left_d = cl_dec;
                phase_d      = cnt_phase;
              end
            end
            sct0_pkg::PH_SW1: begin
              if (req.data_byte != sct0_pkg::NULL_BYTE) begin
                sw1_d   = req.data_byte;
                phase_d = sct0_pkg::PH_SW2;
              end
            end
            sct0_pkg::PH_SW2: begin
              sw2_d        = req.data_byte;
              phase_d      = sct0_pkg::PH_HEADER;
              hdr_cnt_d    = '0;
              data_len_d   = '0;
              bytes_done_d = '0;
              chunk_left_d = '0;
              flag_done_d  = 1'b1;
              done_pulse   = 1'b1;
            end
            default: begin
              // card byte with no place to go
              flag_ovr_d = 1'b1;
            end
          endcase
        end
        sct0_pkg::OP_HOST_TX: begin
          if (queue_count_q >= sct0_pkg::QCNT_W'(sct0_pkg::TX_QUEUE_DEPTH) ||
              (phase_q != sct0_pkg::PH_HEADER && phase_q != sct0_pkg::PH_SEND)) begin
            flag_ovr_d = 1'b1;
          end else begin
            ram_we        = 1'b1;
            queue_count_d = queue_count_q + sct0_pkg::QCNT_W'(1);
            tx_busy_d     = 1'b1;
            if (phase_q == sct0_pkg::PH_HEADER) begin
              hdr_cnt_d = hdr_inc;
              if (hdr_inc == sct0_pkg::HEADER_BYTES) begin
                phase_d    = sct0_pkg::PH_PROC;
                data_len_d = (xfer_len_q == 8'd0) ? sct0_pkg::MAX_LENGTH
                                                  : {1'b0, xfer_len_q};
              end
            end else begin
              bytes_done_d = bd_inc;
              chunk_left_d = cl_dec;
              phase_d      = cnt_phase;
            end
          end
        end
        sct0_pkg::OP_HOST_RX: begin
          rx_wait_d = 1'b0;
        end
        sct0_pkg::OP_TX_SLOT: begin
          if (queue_count_q != '0) begin
            ram_re        = 1'b1;
            tx_fire       = 1'b1;
            q_head_d      = (q_head_q == sct0_pkg::QIDX_W'(sct0_pkg::TX_QUEUE_DEPTH - 1))
                            ? '0 : q_head_q + sct0_pkg::QIDX_W'(1);
            queue_count_d = cnt_dec;
            tx_busy_d     = (cnt_dec != '0);
          end else begin
            tx_busy_d = 1'b0;
          end
        end
        sct0_pkg::OP_START, sct0_pkg::OP_STOP: begin
          q_head_d      = '0;
          queue_count_d = '0;
          tx_busy_d     = 1'b0;
          rx_wait_d     = 1'b0;
          hdr_cnt_d     = '0;
          data_len_d    = '0;
          bytes_done_d  = '0;
          chunk_left_d  = '0;
          phase_d       = (sct0_pkg::opcode_e'(req.opcode) == sct0_pkg::OP_START)
                          ? sct0_pkg::PH_HEADER : sct0_pkg::PH_IDLE;
        end
        sct0_pkg::OP_CLEAR: begin
          flag_done_d = 1'b0;
          flag_ovr_d  = 1'b0;
        end
        default: ;
      endcase
    end

    // Result fields as seen after this request
    s1_d.phase           = phase_d;
    s1_d.tx_valid        = tx_fire;
    s1_d.rx_byte         = rx_hold_d;
    s1_d.rx_ready        = rx_wait_d;
    s1_d.status_word1    = sw1_d;
    s1_d.status_word2    = sw2_d;
    s1_d.command_done    = done_pulse;
    s1_d.done_flag       = flag_done_d;
    s1_d.overrun_flag    = flag_ovr_d;
    s1_d.service_request = ((phase_d == sct0_pkg::PH_HEADER || phase_d == sct0_pkg::PH_SEND) &&
                            !tx_busy_d && queue_count_d == '0) || rx_wait_d;
  end

  // Sequencer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= sct0_pkg::PH_IDLE;
      hdr_cnt_q     <= '0;
      data_len_q    <= '0;
      bytes_done_q  <= '0;
      chunk_left_q  <= '0;
      q_head_q      <= '0;
      queue_count_q <= '0;
      tx_busy_q     <= 1'b0;
      rx_wait_q     <= 1'b0;
      rx_hold_q     <= '0;
      sw1_q         <= '0;
      sw2_q         <= '0;
      flag_done_q   <= 1'b0;
      flag_ovr_q    <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      hdr_cnt_q     <= hdr_cnt_d;
      data_len_q    <= data_len_d;
      bytes_done_q  <= bytes_done_d;
      chunk_left_q  <= chunk_left_d;
      q_head_q      <= q_head_d;
      queue_count_q <= queue_count_d;
      tx_busy_q     <= tx_busy_d;
      rx_wait_q     <= rx_wait_d;
      rx_hold_q     <= rx_hold_d;
      sw1_q         <= sw1_d;
      sw2_q         <= sw2_d;
      flag_done_q   <= flag_done_d;
      flag_ovr_q    <= flag_ovr_d;
    end
  end

  // Transmit queue storage
  sct0_ram #(
    .WIDTH (8),
    .DEPTH (sct0_pkg::TX_QUEUE_DEPTH)
  ) u_tx_queue (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (req.data_byte),
    .re_i    (ram_re),
    .raddr_i (q_head_q),
    .rdata_o (ram_rdata)
  );

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Stage payloads; merge the queue read data on the way to the output
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      out_q         <= s1_q;
      out_tx_byte_q <= s1_q.tx_valid ? ram_rdata : 8'd0;
    end
  end

  // Result port
  assign rsp.valid           = out_valid_q;
  assign rsp.phase           = out_q.phase;
  assign rsp.tx_valid        = out_q.tx_valid;
  assign rsp.tx_byte         = out_tx_byte_q;
  assign rsp.rx_byte         = out_q.rx_byte;
  assign rsp.rx_ready        = out_q.rx_ready;
  assign rsp.status_word1    = out_q.status_word1;
  assign rsp.status_word2    = out_q.status_word2;
  assign rsp.command_done    = out_q.command_done;
  assign rsp.done_flag       = out_q.done_flag;
  assign rsp.overrun_flag    = out_q.overrun_flag;
  assign rsp.service_request = out_q.service_request;

  // Checks
  `SCT0_ASSERT_IMP(a_busy_tracks_fill, 1'b1, tx_busy_q == (queue_count_q != '0))
  `SCT0_ASSERT_IMP(a_no_take_when_held, s1_valid_q && !s1_adv, !req_fire)
  `SCT0_ASSERT_NXT(a_rdata_held_on_stall, s1_valid_q && !s1_adv && s1_q.tx_valid, $stable(ram_rdata))
  `SCT0_ASSERT_IMP(a_data_phase_has_chunk,
                   phase_q == sct0_pkg::PH_SEND || phase_q == sct0_pkg::PH_RECV,
                   chunk_left_q != 9'd0 && bytes_done_q != data_len_q)

endmodule

`default_nettype wire
